// ===== rtl/harsh_driving_event_detector_top_macros.svh =====
// Assertion macros shared by the harsh driving event detector RTL.
`ifndef HARSH_DRIVING_EVENT_DETECTOR_TOP_MACROS_SVH
`define HARSH_DRIVING_EVENT_DETECTOR_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checks that a property holds on every clock edge outside reset.
`define HDD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checks that a condition never occurs on any clock edge outside reset.
`define HDD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define HDD_ASSERT(lbl, clk, rst_n, prop, msg)
`define HDD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== rtl/hdd_pkg.sv =====
// Types and constants shared by the harsh driving event detector.
`timescale 1ns / 1ps

package hdd_pkg;

	localparam int ACCEL_W = 16;
	localparam int COUNT_W = 8;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_THR    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEFT_THR     = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEEDUP_THR  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOWDOWN_THR = 4'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_CNT    = 4'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_LEFT_CNT     = 4'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEEDUP_CNT  = 4'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOWDOWN_CNT = 4'd7;

	// Register reset values.
	localparam logic signed [ACCEL_W-1:0] RST_RIGHT_THR    = 16'sd1408;
	localparam logic signed [ACCEL_W-1:0] RST_LEFT_THR     = -16'sd1408;
	localparam logic signed [ACCEL_W-1:0] RST_SPEEDUP_THR  = 16'sd461;
	localparam logic signed [ACCEL_W-1:0] RST_SLOWDOWN_THR = -16'sd768;
	localparam logic [COUNT_W-1:0] RST_RIGHT_CNT    = 8'd6;
	localparam logic [COUNT_W-1:0] RST_LEFT_CNT     = 8'd6;
	localparam logic [COUNT_W-1:0] RST_SPEEDUP_CNT  = 8'd6;
	localparam logic [COUNT_W-1:0] RST_SLOWDOWN_CNT = 8'd2;

	// Flip hysteresis levels: -5.0 and 3.0 in Q8.8.
	localparam logic signed [ACCEL_W-1:0] FLIP_SET_LEVEL   = -16'sd1280;
	localparam logic signed [ACCEL_W-1:0] FLIP_CLEAR_LEVEL = 16'sd768;

	localparam logic [COUNT_W-1:0] RUN_CNT_MAX = 8'hFF;

	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_RIGHT   = 3'd1,
		EV_LEFT    = 3'd2,
		EV_SPEEDUP = 3'd3,
		EV_BRAKE   = 3'd4
	} event_code_t;

	typedef struct packed {
		logic signed [ACCEL_W-1:0] forward_accel;
		logic signed [ACCEL_W-1:0] lateral_accel;
		logic signed [ACCEL_W-1:0] vertical_accel;
	} sample_t;

	typedef struct packed {
		logic signed [ACCEL_W-1:0] right_thr;
		logic signed [ACCEL_W-1:0] left_thr;
		logic signed [ACCEL_W-1:0] speedup_thr;
		logic signed [ACCEL_W-1:0] slowdown_thr;
		logic [COUNT_W-1:0]        right_cnt;
		logic [COUNT_W-1:0]        left_cnt;
		logic [COUNT_W-1:0]        speedup_cnt;
		logic [COUNT_W-1:0]        slowdown_cnt;
	} cfg_t;

	typedef struct packed {
		event_code_t        cls;
		logic [COUNT_W-1:0] need;
		logic               flip_set;
		logic               flip_clear;
	} class_t;

	typedef struct packed {
		event_code_t event_code;
		logic        flip_event;
		logic        flipped;
	} result_t;

endpackage

// ===== rtl/hdd_if.sv =====
// Valid/ready channel interfaces for samples and results.
`timescale 1ns / 1ps

interface hdd_in_if import hdd_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [ACCEL_W-1:0] forward_accel;
	logic signed [ACCEL_W-1:0] lateral_accel;
	logic signed [ACCEL_W-1:0] vertical_accel;

	modport source (output valid, forward_accel, lateral_accel, vertical_accel, input ready);
	modport sink (input valid, forward_accel, lateral_accel, vertical_accel, output ready);
endinterface

interface hdd_out_if import hdd_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [2:0] event_code;
	logic       flip_event;
	logic       flipped;

	modport source (output valid, event_code, flip_event, flipped, input ready);
	modport sink (input valid, event_code, flip_event, flipped, output ready);
endinterface

// ===== rtl/hdd_cfg_regs.sv =====
// Configuration register file for thresholds and run counts.
`timescale 1ns / 1ps

module hdd_cfg_regs import hdd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// Register writes; an index past the last register is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.right_thr    <= RST_RIGHT_THR;
			cfg_q.left_thr     <= RST_LEFT_THR;
			cfg_q.speedup_thr  <= RST_SPEEDUP_THR;
			cfg_q.slowdown_thr <= RST_SLOWDOWN_THR;
			cfg_q.right_cnt    <= RST_RIGHT_CNT;
			cfg_q.left_cnt     <= RST_LEFT_CNT;
			cfg_q.speedup_cnt  <= RST_SPEEDUP_CNT;
			cfg_q.slowdown_cnt <= RST_SLOWDOWN_CNT;
		end else if (wr_en) begin
			case (wr_index)
				CFG_RIGHT_THR:    cfg_q.right_thr    <= $signed(wr_data);
				CFG_LEFT_THR:     cfg_q.left_thr     <= $signed(wr_data);
				CFG_SPEEDUP_THR:  cfg_q.speedup_thr  <= $signed(wr_data);
				CFG_SLOWDOWN_THR: cfg_q.slowdown_thr <= $signed(wr_data);
				CFG_RIGHT_CNT:    cfg_q.right_cnt    <= wr_data[COUNT_W-1:0];
				CFG_LEFT_CNT:     cfg_q.left_cnt     <= wr_data[COUNT_W-1:0];
				CFG_SPEEDUP_CNT:  cfg_q.speedup_cnt  <= wr_data[COUNT_W-1:0];
				CFG_SLOWDOWN_CNT: cfg_q.slowdown_cnt <= wr_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/hdd_classify.sv =====
// Sorts one sample into a driving class and flip band.
`timescale 1ns / 1ps

module hdd_classify import hdd_pkg::*; (
	input  sample_t smp,
	input  cfg_t    cfg,
	output class_t  cls
);

	// Priority compare: right, left, speed-up, braking, then the flip bands.
	always_comb begin
		cls.cls  = EV_NONE;
		cls.need = '0;
		if (smp.lateral_accel > cfg.right_thr) begin
			cls.cls  = EV_RIGHT;
			cls.need = cfg.right_cnt;
		end else if (smp.lateral_accel < cfg.left_thr) begin
			cls.cls  = EV_LEFT;
			cls.need = cfg.left_cnt;
		end else if (smp.forward_accel >= cfg.speedup_thr) begin
			cls.cls  = EV_SPEEDUP;
			cls.need = cfg.speedup_cnt;
		end else if (smp.forward_accel < cfg.slowdown_thr) begin
			cls.cls  = EV_BRAKE;
			cls.need = cfg.slowdown_cnt;
		end
		// Flip hysteresis bands on the vertical axis.
		cls.flip_set   = (smp.vertical_accel <= FLIP_SET_LEVEL);
		cls.flip_clear = (smp.vertical_accel > FLIP_CLEAR_LEVEL);
	end

endmodule

// ===== rtl/hdd_event_state.sv =====
// Shared run counter and flip state, with the result for each sample.
`timescale 1ns / 1ps

module hdd_event_state import hdd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  class_t             cls,
	output result_t            res,
	output logic [COUNT_W-1:0] run_cnt,
	output logic               flip
);

	logic [COUNT_W-1:0] run_cnt_q;
	logic               flip_q;
	logic [COUNT_W-1:0] cnt_inc;
	logic [COUNT_W-1:0] cnt_next;
	event_code_t        code_next;
	logic               flip_next;

	// Run counter: saturating increment, report and clear at the class count; clear on a sample with no class.
	always_comb begin
		cnt_inc   = (run_cnt_q == RUN_CNT_MAX) ? run_cnt_q : run_cnt_q + 1'b1;
		cnt_next  = '0;
		code_next = EV_NONE;
		if (cls.cls != EV_NONE) begin
			if (cnt_inc >= cls.need) begin
				code_next = cls.cls;
			end else begin
				cnt_next = cnt_inc;
			end
		end
	end

	// Flip detector with hysteresis.
	always_comb begin
		flip_next = flip_q;
		if (cls.flip_set) begin
			flip_next = 1'b1;
		end else if (cls.flip_clear) begin
			flip_next = 1'b0;
		end
	end

	// Result for the sample in the input register.
	assign res = {code_next, flip_next ^ flip_q, flip_next};

	// State moves on only when the sample's result is committed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_cnt_q <= '0;
			flip_q    <= 1'b0;
		end else if (advance) begin
			run_cnt_q <= cnt_next;
			flip_q    <= flip_next;
		end
	end

	assign run_cnt = run_cnt_q;
	assign flip    = flip_q;

endmodule

// ===== rtl/harsh_driving_event_detector_top.sv =====
// Top level of the harsh driving event detector.
//
//   Channel  Dir  Handshake            Payload
//   sample   in   valid/ready          forward_accel, lateral_accel, vertical_accel
//   result   out  valid/ready          event_code, flip_event, flipped
//   config   in   wr_en, no stall      wr_index, wr_data
//
// One sample per cycle while the result channel is not stalled; each sample passes
// through the input register, the classify and state update logic and the result
// register before its result is offered.
// Reset sets the configuration registers to their defaults, the counter and flip state to zero.
// A stalled result holds the result register; one more sample waits in the
// input register, then sample.ready drops.
`timescale 1ns / 1ps
`include "harsh_driving_event_detector_top_macros.svh"

module harsh_driving_event_detector_top import hdd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	hdd_in_if.sink                sample,
	hdd_out_if.source             result,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	cfg_t               cfg;
	class_t             cls;
	result_t            res;
	result_t            result_q;
	sample_t            sample_s1;
	logic               valid_s1;
	logic               out_valid_q;
	logic               advance;
	logic               take;
	logic [COUNT_W-1:0] run_cnt;
	logic               flip;

	hdd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	hdd_classify u_classify (
		.smp (sample_s1),
		.cfg (cfg),
		.cls (cls)
	);

	hdd_event_state u_state (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.cls     (cls),
		.res     (res),
		.run_cnt (run_cnt),
		.flip    (flip)
	);

	// Handshake: a sample moves on when the result register is free or draining.
	assign advance      = valid_s1 && (!out_valid_q || result.ready);
	assign sample.ready = !valid_s1 || advance;
	assign take         = sample.valid && sample.ready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sample_s1.forward_accel  <= sample.forward_accel;
			sample_s1.lateral_accel  <= sample.lateral_accel;
			sample_s1.vertical_accel <= sample.vertical_accel;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= res;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.event_code = result_q.event_code;
	assign result.flip_event = result_q.flip_event;
	assign result.flipped    = result_q.flipped;

	// A reported event always leaves the run counter cleared.
	`HDD_ASSERT(a_cnt_clear, clk, arst_n, (advance && res.event_code != EV_NONE) |=> (run_cnt == '0), "run counter not cleared after event")
	// A reported toggle must change the stored flip state.
	`HDD_ASSERT(a_flip_toggle, clk, arst_n, (advance && res.flip_event) |=> (flip != $past(flip)), "flip event without state change")
	// Back pressure only when both registers hold a pending transaction.
	`HDD_ASSERT(a_ready_low, clk, arst_n, !sample.ready |-> (valid_s1 && out_valid_q && !result.ready), "sample stalled without full pipeline")
	// A valid result never carries an event code outside the defined set.
	`HDD_ASSERT_NEVER(a_code_range, clk, arst_n, out_valid_q && (result_q.event_code > EV_BRAKE), "undefined event code on result")

endmodule
